@@ hdl/segment_intersection_point_core_defines.svh @@
// Assertion macros shared by the segment intersection RTL.
// Needs clk and rst_n in the scope of every use.
`ifndef SEGMENT_INTERSECTION_POINT_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SIP_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error(msg);
`define SIP_ASSERT_NEXT(lbl, pre, post, msg) lbl: assert property (@(posedge clk) \
    disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SIP_ASSERT(lbl, prop, msg)
`define SIP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/sip_pkg.sv @@
// Shared constants for the segment intersection core.
// No dependencies.
package sip_pkg;
    localparam int FIELD_W         = 32;
    localparam int FRAC_BITS       = 24;
    localparam int TOL_W           = 25;
    localparam int QUOT_BITS       = 42;
    localparam int COORD_WIDTH_DEF = 32;
endpackage

@@ hdl/sip_ifs.sv @@
// Channel interfaces of the segment intersection core: input items,
// result items and the tolerance write port. Depends on sip_pkg.
interface sip_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sip_pkg::FIELD_W-1:0]    a_start_x;
    logic signed [sip_pkg::FIELD_W-1:0]    a_start_y;
    logic signed [sip_pkg::FIELD_W-1:0]    a_end_x;
    logic signed [sip_pkg::FIELD_W-1:0]    a_end_y;
    logic signed [sip_pkg::FIELD_W-1:0]    b_start_x;
    logic signed [sip_pkg::FIELD_W-1:0]    b_start_y;
    logic signed [sip_pkg::FIELD_W-1:0]    b_end_x;
    logic signed [sip_pkg::FIELD_W-1:0]    b_end_y;
    modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sip_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic signed [sip_pkg::FIELD_W-1:0]    cross_x;
    logic signed [sip_pkg::FIELD_W-1:0]    cross_y;
    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

interface sip_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sip_pkg::TOL_W-1:0]         data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

@@ hdl/segment_intersection_point_core.sv @@
// Segment intersection core: pipelined cross products, two restoring
// dividers and the point multiply. Depends on sip_pkg, sip_ifs and the defines header.
//
// Usage: seg_in carries one pair of segments (A start/end, B start/end, signed
// Q16.16) per item; seg_out returns one item per input: hit and the crossing
// point, zero on a miss. cfg writes the tolerance (24 fraction bits); write it
// only while no item is in flight. cfg is always ready.
// The divider is an entry register plus 42 stages, one quotient bit per
// stage for each of the two parameters.
// Throughput: one item per cycle while seg_out does not stall.
// Every stage has its own valid bit; a stage takes a new item when it is
// empty or its successor moves, so bubbles close up while seg_out stalls and
// seg_in stays ready until the pipeline is full.
// Reset clears all valid bits and sets the tolerance to zero.
`include "segment_intersection_point_core_defines.svh"
module segment_intersection_point_core #(
    parameter int COORD_WIDTH = sip_pkg::COORD_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sip_in_if.sink        seg_in,
    sip_out_if.source     seg_out,
    sip_cfg_if.sink       cfg
);
    localparam int FW   = sip_pkg::FIELD_W;
    localparam int FB   = sip_pkg::FRAC_BITS;
    localparam int QB   = sip_pkg::QUOT_BITS;
    localparam int TW   = sip_pkg::TOL_W;
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * CW + 2;
    localparam int MW   = 2 * CW + 1;
    localparam int NW   = MW + FB;
    localparam int KW   = MW + QB;
    localparam int EW   = QB + 1;
    localparam int UHW  = QB - 1 - FB;
    localparam int OW   = UHW + DW + 1;
    localparam int RW   = OW + 2;

    localparam logic [QB-1:0] QSAT = QB'(1) << (QB - 2);
    localparam logic signed [EW-1:0] ONE = EW'(1) <<< FB;
    localparam logic signed [RW-1:0] PMAX = RW'(signed'({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [RW-1:0] NMIN = RW'(signed'({1'b1, {(CW-1){1'b0}}}));

    typedef struct packed {
        logic [MW-1:0]           den;
        logic [NW-1:0]           rem_u;
        logic [NW-1:0]           rem_v;
        logic [QB-1:0]           q_u;
        logic [QB-1:0]           q_v;
        logic                    neg_u;
        logic                    neg_v;
        logic                    nz;
        logic signed [CW-1:0]    x1;
        logic signed [CW-1:0]    y1;
        logic signed [DW-1:0]    xa;
        logic signed [DW-1:0]    ya;
    } div_t;

    function automatic logic signed [CW-1:0] coord(input logic [FW-1:0] f);
        logic [CW+FW-1:0] e;
        e = {{CW{1'b0}}, f};
        return signed'(e[CW-1:0]);
    endfunction

    // configuration
    logic [TW-1:0] tol_reg;
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    // stage valids and advance chain
    logic            a_v_reg, b_v_reg, c_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg;
    logic [QB:0]     div_v_reg;
    logic            en_a, en_b, en_c, en_e, en_f, en_g, en_h;
    logic [QB+1:0]   div_en;

    always_comb
    begin
        en_h = !h_v_reg || seg_out.ready;
        en_g = !g_v_reg || en_h;
        en_f = !f_v_reg || en_g;
        en_e = !e_v_reg || en_f;
        div_en[QB+1] = en_e;
        for (int k = QB; k >= 0; k--)
            div_en[k] = !div_v_reg[k] || div_en[k+1];
        en_c = !c_v_reg || div_en[0];
        en_b = !b_v_reg || en_c;
        en_a = !a_v_reg || en_b;
    end
    assign seg_in.ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            div_v_reg <= '0;
            e_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            g_v_reg   <= 1'b0;
            h_v_reg   <= 1'b0;
        end
        else
        begin
            if (en_a) a_v_reg <= seg_in.valid;
            if (en_b) b_v_reg <= a_v_reg;
            if (en_c) c_v_reg <= b_v_reg;
            if (div_en[0]) div_v_reg[0] <= c_v_reg;
            for (int k = 1; k <= QB; k++)
                if (div_en[k]) div_v_reg[k] <= div_v_reg[k-1];
            if (en_e) e_v_reg <= div_v_reg[QB];
            if (en_f) f_v_reg <= e_v_reg;
            if (en_g) g_v_reg <= f_v_reg;
            if (en_h) h_v_reg <= g_v_reg;
        end
    end

    // stage A: differences
    logic signed [DW-1:0] a_xa_reg, a_ya_reg, a_xb_reg, a_yb_reg, a_xs_reg, a_ys_reg;
    logic signed [CW-1:0] a_x1_reg, a_y1_reg;
    logic signed [CW-1:0] x1_c, y1_c, x2_c, y2_c, x3_c, y3_c, x4_c, y4_c;

    always_comb
    begin
        x1_c = coord(seg_in.a_start_x);
        y1_c = coord(seg_in.a_start_y);
        x2_c = coord(seg_in.a_end_x);
        y2_c = coord(seg_in.a_end_y);
        x3_c = coord(seg_in.b_start_x);
        y3_c = coord(seg_in.b_start_y);
        x4_c = coord(seg_in.b_end_x);
        y4_c = coord(seg_in.b_end_y);
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_xa_reg <= DW'(x2_c) - DW'(x1_c);
            a_ya_reg <= DW'(y2_c) - DW'(y1_c);
            a_xb_reg <= DW'(x4_c) - DW'(x3_c);
            a_yb_reg <= DW'(y4_c) - DW'(y3_c);
            a_xs_reg <= DW'(x3_c) - DW'(x1_c);
            a_ys_reg <= DW'(y3_c) - DW'(y1_c);
            a_x1_reg <= x1_c;
            a_y1_reg <= y1_c;
        end
    end

    // stage B: six products
    logic signed [PW-1:0] b_d1_reg, b_d2_reg, b_u1_reg, b_u2_reg, b_v1_reg, b_v2_reg;
    logic signed [CW-1:0] b_x1_reg, b_y1_reg;
    logic signed [DW-1:0] b_xa_reg, b_ya_reg;

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_d1_reg <= PW'(a_xa_reg) * PW'(a_yb_reg);
            b_d2_reg <= PW'(a_ya_reg) * PW'(a_xb_reg);
            b_u1_reg <= PW'(a_xs_reg) * PW'(a_yb_reg);
            b_u2_reg <= PW'(a_ys_reg) * PW'(a_xb_reg);
            b_v1_reg <= PW'(a_xs_reg) * PW'(a_ya_reg);
            b_v2_reg <= PW'(a_ys_reg) * PW'(a_xa_reg);
            b_x1_reg <= a_x1_reg;
            b_y1_reg <= a_y1_reg;
            b_xa_reg <= a_xa_reg;
            b_ya_reg <= a_ya_reg;
        end
    end

    // stage C: denominator and numerators
    logic signed [PW-1:0] c_den_reg, c_tu_reg, c_tv_reg;
    logic signed [CW-1:0] c_x1_reg, c_y1_reg;
    logic signed [DW-1:0] c_xa_reg, c_ya_reg;

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_den_reg <= b_d1_reg - b_d2_reg;
            c_tu_reg  <= b_u1_reg - b_u2_reg;
            c_tv_reg  <= b_v1_reg - b_v2_reg;
            c_x1_reg  <= b_x1_reg;
            c_y1_reg  <= b_y1_reg;
            c_xa_reg  <= b_xa_reg;
            c_ya_reg  <= b_ya_reg;
        end
    end

    // divider entry: magnitudes and signs
    div_t            div_reg [QB+1];
    div_t            div_in_next;
    logic [PW-1:0]   mag_d, mag_u, mag_v;

    always_comb
    begin
        mag_d = c_den_reg[PW-1] ? PW'(-c_den_reg) : PW'(c_den_reg);
        mag_u = c_tu_reg[PW-1] ? PW'(-c_tu_reg) : PW'(c_tu_reg);
        mag_v = c_tv_reg[PW-1] ? PW'(-c_tv_reg) : PW'(c_tv_reg);
        div_in_next.den   = mag_d[MW-1:0];
        div_in_next.rem_u = {mag_u[MW-1:0], {FB{1'b0}}};
        div_in_next.rem_v = {mag_v[MW-1:0], {FB{1'b0}}};
        div_in_next.q_u   = '0;
        div_in_next.q_v   = '0;
        div_in_next.neg_u = c_tu_reg[PW-1] ^ c_den_reg[PW-1];
        div_in_next.neg_v = c_tv_reg[PW-1] ^ c_den_reg[PW-1];
        div_in_next.nz    = (c_den_reg != '0);
        div_in_next.x1    = c_x1_reg;
        div_in_next.y1    = c_y1_reg;
        div_in_next.xa    = c_xa_reg;
        div_in_next.ya    = c_ya_reg;
    end

    always_ff @(posedge clk)
    begin
        if (div_en[0])
            div_reg[0] <= div_in_next;
    end

    // restoring division, one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int SH = QB - 1 - k;
        logic [KW-1:0] dsh;
        logic          ge_u, ge_v;
        div_t          step_next;

        always_comb
        begin
            step_next = div_reg[k];
            dsh  = KW'(div_reg[k].den) << SH;
            ge_u = KW'(div_reg[k].rem_u) >= dsh;
            ge_v = KW'(div_reg[k].rem_v) >= dsh;
            if (ge_u)
                step_next.rem_u = NW'(KW'(div_reg[k].rem_u) - dsh);
            if (ge_v)
                step_next.rem_v = NW'(KW'(div_reg[k].rem_v) - dsh);
            step_next.q_u = {div_reg[k].q_u[QB-2:0], ge_u};
            step_next.q_v = {div_reg[k].q_v[QB-2:0], ge_v};
        end

        always_ff @(posedge clk)
        begin
            if (div_en[k+1])
                div_reg[k+1] <= step_next;
        end
    end

    // stage E: saturate, tolerance test, operand magnitudes
    logic [QB-1:0]          umag, vmag;
    logic signed [EW-1:0]   u_s, v_s, tol_s;
    logic                   e_hit_next;
    logic [DW-1:0]          ax_c, ay_c;

    logic                   e_hit_reg;
    logic [QB-2:0]          e_umag_reg;
    logic [DW-1:0]          e_ax_reg, e_ay_reg;
    logic                   e_sx_reg, e_sy_reg;
    logic signed [CW-1:0]   e_x1_reg, e_y1_reg;

    always_comb
    begin
        umag  = (div_reg[QB].q_u > QSAT) ? QSAT : div_reg[QB].q_u;
        vmag  = (div_reg[QB].q_v > QSAT) ? QSAT : div_reg[QB].q_v;
        u_s   = div_reg[QB].neg_u ? -signed'(EW'(umag)) : signed'(EW'(umag));
        v_s   = div_reg[QB].neg_v ? -signed'(EW'(vmag)) : signed'(EW'(vmag));
        tol_s = signed'(EW'(tol_reg));
        e_hit_next = div_reg[QB].nz
                     && (u_s <= ONE + tol_s) && (u_s >= -tol_s)
                     && (v_s <= ONE + tol_s) && (v_s >= -tol_s);
        ax_c = div_reg[QB].xa[DW-1] ? DW'(-div_reg[QB].xa) : DW'(div_reg[QB].xa);
        ay_c = div_reg[QB].ya[DW-1] ? DW'(-div_reg[QB].ya) : DW'(div_reg[QB].ya);
    end

    always_ff @(posedge clk)
    begin
        if (en_e)
        begin
            e_hit_reg  <= e_hit_next;
            e_umag_reg <= umag[QB-2:0];
            e_ax_reg   <= ax_c;
            e_ay_reg   <= ay_c;
            e_sx_reg   <= div_reg[QB].neg_u ^ div_reg[QB].xa[DW-1];
            e_sy_reg   <= div_reg[QB].neg_u ^ div_reg[QB].ya[DW-1];
            e_x1_reg   <= div_reg[QB].x1;
            e_y1_reg   <= div_reg[QB].y1;
        end
    end

    // stage F: split u into high and low parts, four partial products
    logic [UHW+DW-1:0]      f_phx_reg, f_phy_reg;
    logic [FB+DW-1:0]       f_plx_reg, f_ply_reg;
    logic                   f_hit_reg, f_sx_reg, f_sy_reg;
    logic signed [CW-1:0]   f_x1_reg, f_y1_reg;

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            f_phx_reg <= (UHW+DW)'(e_umag_reg[QB-2:FB]) * (UHW+DW)'(e_ax_reg);
            f_phy_reg <= (UHW+DW)'(e_umag_reg[QB-2:FB]) * (UHW+DW)'(e_ay_reg);
            f_plx_reg <= (FB+DW)'(e_umag_reg[FB-1:0]) * (FB+DW)'(e_ax_reg);
            f_ply_reg <= (FB+DW)'(e_umag_reg[FB-1:0]) * (FB+DW)'(e_ay_reg);
            f_hit_reg <= e_hit_reg;
            f_sx_reg  <= e_sx_reg;
            f_sy_reg  <= e_sy_reg;
            f_x1_reg  <= e_x1_reg;
            f_y1_reg  <= e_y1_reg;
        end
    end

    // stage G: offset magnitudes, product truncated to Q16.16
    logic [OW-1:0]          g_offx_reg, g_offy_reg;
    logic                   g_hit_reg, g_sx_reg, g_sy_reg;
    logic signed [CW-1:0]   g_x1_reg, g_y1_reg;

    always_ff @(posedge clk)
    begin
        if (en_g)
        begin
            g_offx_reg <= OW'(f_phx_reg) + OW'(f_plx_reg >> FB);
            g_offy_reg <= OW'(f_phy_reg) + OW'(f_ply_reg >> FB);
            g_hit_reg  <= f_hit_reg;
            g_sx_reg   <= f_sx_reg;
            g_sy_reg   <= f_sy_reg;
            g_x1_reg   <= f_x1_reg;
            g_y1_reg   <= f_y1_reg;
        end
    end

    // stage H: add to the start point, saturate, zero on a miss
    logic signed [RW-1:0]     rx, ry, offx_s, offy_s;
    logic signed [CW-1:0]     sat_x, sat_y;
    logic signed [CW+FW-1:0]  ext_x, ext_y;
    logic                     h_hit_reg;
    logic signed [FW-1:0]     h_x_reg, h_y_reg;

    always_comb
    begin
        offx_s = signed'(RW'(g_offx_reg));
        offy_s = signed'(RW'(g_offy_reg));
        rx = RW'(g_x1_reg) + (g_sx_reg ? -offx_s : offx_s);
        ry = RW'(g_y1_reg) + (g_sy_reg ? -offy_s : offy_s);
        if (rx > PMAX)
            sat_x = PMAX[CW-1:0];
        else if (rx < NMIN)
            sat_x = NMIN[CW-1:0];
        else
            sat_x = rx[CW-1:0];
        if (ry > PMAX)
            sat_y = PMAX[CW-1:0];
        else if (ry < NMIN)
            sat_y = NMIN[CW-1:0];
        else
            sat_y = ry[CW-1:0];
        ext_x = (CW+FW)'(sat_x);
        ext_y = (CW+FW)'(sat_y);
    end

    always_ff @(posedge clk)
    begin
        if (en_h)
        begin
            h_hit_reg <= g_hit_reg;
            h_x_reg   <= g_hit_reg ? ext_x[FW-1:0] : '0;
            h_y_reg   <= g_hit_reg ? ext_y[FW-1:0] : '0;
        end
    end

    assign seg_out.valid   = h_v_reg;
    assign seg_out.hit     = h_hit_reg;
    assign seg_out.cross_x = h_x_reg;
    assign seg_out.cross_y = h_y_reg;

    logic out_pt_zero, par_at_exit;
    assign out_pt_zero = (seg_out.cross_x == '0) && (seg_out.cross_y == '0);
    assign par_at_exit = div_v_reg[QB] && !div_reg[QB].nz && en_e;

    `SIP_ASSERT(a_miss_zero, (seg_out.valid && !seg_out.hit) |-> out_pt_zero, "miss with a point")
    `SIP_ASSERT(a_ready_flow, seg_out.ready |-> seg_in.ready, "input blocked while output drains")
    `SIP_ASSERT_NEXT(a_hold_a, a_v_reg && !en_a, a_v_reg, "stalled item dropped from stage A")
    `SIP_ASSERT_NEXT(a_par_miss, par_at_exit, !e_hit_reg, "parallel segments flagged as hit")
endmodule
